@@ hw/rtl/miw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// miw_pkg
// Shared types, widths and codes for the minimum-image wrap pipeline.
// ----------------------------------------------------------------------------
package miw_pkg;

	localparam int ENTRY_W    = 21;               // one packed matrix entry
	localparam int COL_W      = 3 * ENTRY_W;      // one packed matrix column
	localparam int DISP_W     = 32;               // Q15.16 displacement
	localparam int FRAC_SHIFT = 36;               // fractional coords in Q.36
	localparam int FRAC_W     = FRAC_SHIFT + 1;   // |f| <= 0.5
	localparam int OUT_SHIFT  = 30;               // Q.46 -> Q.16
	localparam int FSUM_W     = DISP_W + ENTRY_W + 2;
	localparam int ACC_W      = FRAC_W + ENTRY_W + 2;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_X    = 2'd1,
		MODE_XY   = 2'd2,
		MODE_XYZ  = 2'd3
	} mode_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD_MODE = 3'd0,
		REG_BOX_A       = 3'd1,
		REG_BOX_B       = 3'd2,
		REG_BOX_C       = 3'd3,
		REG_INV_A       = 3'd4,
		REG_INV_B       = 3'd5,
		REG_INV_C       = 3'd6
	} cfg_reg_e;

	// data that rides along with each item through every stage
	typedef struct packed {
		mode_e                   mode;
		logic [2:0][DISP_W-1:0]  disp;
		logic                    last;
	} side_t;

	// which axes are periodic for a given mode (bit 0 = x)
	function automatic logic [2:0] axis_enable(input mode_e mode);
		logic [2:0] en;
		case (mode)
			MODE_NONE: en = 3'b000;
			MODE_X:    en = 3'b001;
			MODE_XY:   en = 3'b011;
			MODE_XYZ:  en = 3'b111;
			default:   en = 3'b000;
		endcase
		return en;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/miw_matvec.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// miw_matvec
// 3x3 matrix times vector over the periodic columns: one stage of
// registered products, one stage of registered row sums.
// ----------------------------------------------------------------------------
module miw_matvec #(
	parameter int VEC_W = miw_pkg::DISP_W
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic [2:0][VEC_W-1:0]                       in_vec,
	input  miw_pkg::side_t                              in_side,
	input  logic [2:0][miw_pkg::COL_W-1:0]              mat_cols,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic [2:0][VEC_W+miw_pkg::ENTRY_W+1:0]      out_sum,
	output miw_pkg::side_t                              out_side
);
	import miw_pkg::*;

	localparam int PROD_W = VEC_W + ENTRY_W;
	localparam int SUM_W  = PROD_W + 2;

	logic [2:0]               col_en;
	logic signed [PROD_W-1:0] prod_c  [3][3];
	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic signed [SUM_W-1:0]  sum_c   [3];
	logic [2:0][SUM_W-1:0]    sum_s2;
	side_t                    side_s1;
	side_t                    side_s2;
	logic                     vld_s1;
	logic                     vld_s2;
	logic                     en_s1;
	logic                     en_s2;

	assign en_s2    = !vld_s2 || out_ready;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	assign col_en = axis_enable(in_side.mode);

	// row i, column j: entry i of column j times vector element j
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (col_en[j])
					prod_c[i][j] = PROD_W'($signed(mat_cols[j][ENTRY_W*i +: ENTRY_W]))
						* PROD_W'($signed(in_vec[j]));
				else
					prod_c[i][j] = '0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			sum_c[i] = SUM_W'(prod_s1[i][0]) + SUM_W'(prod_s1[i][1])
				+ SUM_W'(prod_s1[i][2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			prod_s1 <= prod_c;
			side_s1 <= in_side;
		end
		if (en_s2 && vld_s1) begin
			for (int i = 0; i < 3; i++)
				sum_s2[i] <= sum_c[i];
			side_s2 <= side_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_sum   = sum_s2;
	assign out_side  = side_s2;

endmodule
`default_nettype wire

@@ hw/rtl/miw_frac.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// miw_frac
// Removes the nearest integer (ties away from zero) from each Q.36
// fractional coordinate; one register stage.
// ----------------------------------------------------------------------------
module miw_frac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [2:0][miw_pkg::FSUM_W-1:0]       in_sum,
	input  miw_pkg::side_t                        in_side,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [2:0][miw_pkg::FRAC_W-1:0]       out_frac,
	output miw_pkg::side_t                        out_side
);
	import miw_pkg::*;

	localparam logic [FRAC_W-1:0] FRAC_HALF = FRAC_W'(1) << (FRAC_SHIFT - 1);

	logic [2:0]                  neg;
	logic [2:0][FSUM_W-1:0]      mag;
	logic [2:0][FRAC_SHIFT-1:0]  low;
	logic [2:0][FRAC_W-1:0]      fmag;
	logic [2:0][FRAC_W-1:0]      frac_c;
	logic [2:0][FRAC_W-1:0]      frac_s1;
	side_t                       side_s1;
	logic                        vld_s1;
	logic                        en_s1;

	assign en_s1    = !vld_s1 || out_ready;
	assign in_ready = en_s1;

	// on the magnitude: flipping the half bit and subtracting a half gives
	// the low part minus its nearest integer
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg[i]    = in_sum[i][FSUM_W-1];
			mag[i]    = neg[i] ? (FSUM_W'(0) - in_sum[i]) : in_sum[i];
			low[i]    = mag[i][FRAC_SHIFT-1:0];
			fmag[i]   = FRAC_W'({~low[i][FRAC_SHIFT-1], low[i][FRAC_SHIFT-2:0]})
				- FRAC_HALF;
			frac_c[i] = neg[i] ? (FRAC_W'(0) - fmag[i]) : fmag[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en_s1)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			frac_s1 <= frac_c;
			side_s1 <= in_side;
		end
	end

	assign out_valid = vld_s1;
	assign out_frac  = frac_s1;
	assign out_side  = side_s1;

endmodule
`default_nettype wire

@@ hw/rtl/miw_round.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// miw_round
// Output stage: Q.46 to Q.16 rounding (ties away from zero), saturation,
// and pass-through of the non-periodic axes.
// ----------------------------------------------------------------------------
module miw_round (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [2:0][miw_pkg::ACC_W-1:0]        in_acc,
	input  miw_pkg::side_t                        in_side,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [2:0][miw_pkg::DISP_W-1:0]       out_wrapped,
	output logic                                  out_last
);
	import miw_pkg::*;

	localparam int QSUM_W = ACC_W + 2;
	localparam int Q_W    = QSUM_W - OUT_SHIFT;
	localparam logic [QSUM_W-1:0] RND      = QSUM_W'(1) << (OUT_SHIFT - 1);
	localparam logic [Q_W-1:0]    POS_MAX  = Q_W'((64'd1 << (DISP_W - 1)) - 64'd1);
	localparam logic [Q_W-1:0]    NEG_MAG  = Q_W'(64'd1 << (DISP_W - 1));
	localparam logic [DISP_W-1:0] SAT_POS  = {1'b0, {(DISP_W-1){1'b1}}};
	localparam logic [DISP_W-1:0] SAT_NEG  = {1'b1, {(DISP_W-1){1'b0}}};

	logic [2:0]               ax_en;
	logic [2:0]               neg;
	logic [2:0][ACC_W-1:0]    mag;
	logic [2:0][QSUM_W-1:0]   qsum;
	logic [2:0][Q_W-1:0]      q;
	logic [2:0][DISP_W-1:0]   rnd;
	logic [2:0][DISP_W-1:0]   wrap_c;
	logic [2:0][DISP_W-1:0]   wrap_s1;
	logic                     last_s1;
	logic                     vld_s1;
	logic                     en_s1;

	assign en_s1    = !vld_s1 || out_ready;
	assign in_ready = en_s1;

	assign ax_en = axis_enable(in_side.mode);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg[i]  = in_acc[i][ACC_W-1];
			mag[i]  = neg[i] ? (ACC_W'(0) - in_acc[i]) : in_acc[i];
			qsum[i] = QSUM_W'(mag[i]) + RND;
			q[i]    = qsum[i][QSUM_W-1:OUT_SHIFT];
			if (neg[i])
				rnd[i] = (q[i] > NEG_MAG) ? SAT_NEG : DISP_W'(Q_W'(0) - q[i]);
			else
				rnd[i] = (q[i] > POS_MAX) ? SAT_POS : DISP_W'(q[i]);
			wrap_c[i] = ax_en[i] ? rnd[i] : in_side.disp[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en_s1)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			wrap_s1 <= wrap_c;
			last_s1 <= in_side.last;
		end
	end

	assign out_valid   = vld_s1;
	assign out_wrapped = wrap_s1;
	assign out_last    = last_s1;

endmodule
`default_nettype wire

@@ hw/rtl/minimum_image_wrap_core.sv @@
`default_nettype none
// Pipeline: six register stages from input accept to result valid.
// Throughput: one item per cycle unless out_ready stalls; stages are products,
// sums, fraction, products, sums, round, each with its own valid and stall.
// Reset: clears all stage valid bits and the configuration registers to zero.
// Configuration writes are always accepted (cfg_ready tied high).
// ----------------------------------------------------------------------------
// minimum_image_wrap_core
// Minimum-image wrap of a displacement in a triclinic box: inverse box
// matrix, nearest-integer removal, box matrix, rounded and saturated.
// ----------------------------------------------------------------------------
module minimum_image_wrap_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [miw_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [miw_pkg::COL_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [miw_pkg::DISP_W-1:0]    disp_x,
	input  logic signed [miw_pkg::DISP_W-1:0]    disp_y,
	input  logic signed [miw_pkg::DISP_W-1:0]    disp_z,
	input  logic                                 batch_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [miw_pkg::DISP_W-1:0]    wrapped_x,
	output logic signed [miw_pkg::DISP_W-1:0]    wrapped_y,
	output logic signed [miw_pkg::DISP_W-1:0]    wrapped_z,
	output logic                                 batch_last
);
	import miw_pkg::*;

	mode_e                    period_mode_q;
	logic [2:0][COL_W-1:0]    box_cols_q;
	logic [2:0][COL_W-1:0]    inv_cols_q;

	side_t                    side_in;
	logic                     fs_valid;
	logic                     fs_ready;
	logic [2:0][FSUM_W-1:0]   fs_sum;
	side_t                    fs_side;
	logic                     fr_valid;
	logic                     fr_ready;
	logic [2:0][FRAC_W-1:0]   fr_frac;
	side_t                    fr_side;
	logic                     ac_valid;
	logic                     ac_ready;
	logic [2:0][ACC_W-1:0]    ac_sum;
	side_t                    ac_side;
	logic [2:0][DISP_W-1:0]   wrapped;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_mode_q <= MODE_NONE;
			box_cols_q    <= '0;
			inv_cols_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_PERIOD_MODE: period_mode_q <= mode_e'(cfg_data[1:0]);
				REG_BOX_A:       box_cols_q[0] <= cfg_data;
				REG_BOX_B:       box_cols_q[1] <= cfg_data;
				REG_BOX_C:       box_cols_q[2] <= cfg_data;
				REG_INV_A:       inv_cols_q[0] <= cfg_data;
				REG_INV_B:       inv_cols_q[1] <= cfg_data;
				REG_INV_C:       inv_cols_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		side_in.mode    = period_mode_q;
		side_in.disp[0] = disp_x;
		side_in.disp[1] = disp_y;
		side_in.disp[2] = disp_z;
		side_in.last    = batch_end;
	end

	// displacement to fractional coordinates
	miw_matvec #(
		.VEC_W(DISP_W)
	) u_to_frac (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_vec   (side_in.disp),
		.in_side  (side_in),
		.mat_cols (inv_cols_q),
		.out_valid(fs_valid),
		.out_ready(fs_ready),
		.out_sum  (fs_sum),
		.out_side (fs_side)
	);

	miw_frac u_frac (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fs_valid),
		.in_ready (fs_ready),
		.in_sum   (fs_sum),
		.in_side  (fs_side),
		.out_valid(fr_valid),
		.out_ready(fr_ready),
		.out_frac (fr_frac),
		.out_side (fr_side)
	);

	// wrapped fractional coordinates back to Cartesian
	miw_matvec #(
		.VEC_W(FRAC_W)
	) u_to_cart (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fr_valid),
		.in_ready (fr_ready),
		.in_vec   (fr_frac),
		.in_side  (fr_side),
		.mat_cols (box_cols_q),
		.out_valid(ac_valid),
		.out_ready(ac_ready),
		.out_sum  (ac_sum),
		.out_side (ac_side)
	);

	miw_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (ac_valid),
		.in_ready   (ac_ready),
		.in_acc     (ac_sum),
		.in_side    (ac_side),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_wrapped(wrapped),
		.out_last   (batch_last)
	);

	assign wrapped_x = wrapped[0];
	assign wrapped_y = wrapped[1];
	assign wrapped_z = wrapped[2];

endmodule
`default_nettype wire

@@ test/tb_minimum_image_wrap_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_minimum_image_wrap_core
// Self-checking bench for the minimum-image wrap core. An initial block queues
// register writes and displacement items. A bursty valid/ready driver feeds
// them to the core. A monitor predicts every wrapped vector in 64-bit fixed
// point and checks the results in order while the output side stalls.
// ----------------------------------------------------------------------------
module tb_minimum_image_wrap_core;
	import miw_pkg::*;

	localparam int     CLK_HALF   = 10;
	localparam longint TIMEOUT_NS = 64'd10_000_000;
	localparam longint ONE_Q16    = 65536;
	localparam longint DISP_MAX   = 2147483647;
	localparam longint DISP_MIN   = -DISP_MAX - 1;
	localparam longint ENTRY_MAX  = 1048575;
	localparam longint ENTRY_MIN  = -ENTRY_MAX - 1;
	localparam real    BOX_ONE    = 1024.0;
	localparam real    INV_ONE    = 1048576.0;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7; // decodes to no register

	typedef enum logic [1:0] {OP_DISP, OP_CFG, OP_SYNC} op_kind_e;
	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BLOCKS} rx_style_e;

	typedef struct {
		op_kind_e                  kind;
		logic signed [DISP_W-1:0]  x, y, z;
		logic                      last;
		logic [CFG_IDX_W-1:0]      idx;
		logic [COL_W-1:0]          data;
	} pend_op_t;

	typedef struct {
		logic signed [DISP_W-1:0]  x, y, z;
		logic                      last;
	} wrap_result_t;

	logic                        clk        = 1'b0;
	logic                        arst_n     = 1'b0;
	logic                        cfg_valid  = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index  = '0;
	logic [COL_W-1:0]            cfg_data   = '0;
	logic                        in_valid   = 1'b0;
	logic                        in_ready;
	logic signed [DISP_W-1:0]    disp_x     = '0;
	logic signed [DISP_W-1:0]    disp_y     = '0;
	logic signed [DISP_W-1:0]    disp_z     = '0;
	logic                        batch_end  = 1'b0;
	logic                        out_valid;
	logic                        out_ready  = 1'b0;
	logic signed [DISP_W-1:0]    wrapped_x;
	logic signed [DISP_W-1:0]    wrapped_y;
	logic signed [DISP_W-1:0]    wrapped_z;
	logic                        batch_last;

	// shadow of the core's registers
	mode_e               period_sh = MODE_NONE;
	logic [COL_W-1:0]    box_sh[3] = '{default: '0};
	logic [COL_W-1:0]    inv_sh[3] = '{default: '0};

	pend_op_t            pending[$];
	wrap_result_t        wrap_due[$];
	logic                in_taken   = 1'b0;
	logic                cfg_taken  = 1'b0;
	int                  fail_count = 0;
	int                  burst_left = 8;
	int                  gap_left   = 0;
	int                  rx_cycle   = 0;
	int                  rx_hold    = 0;
	rx_style_e           rx_style   = RX_OPEN;
	real                 box_span   = 10.0;

	minimum_image_wrap_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.disp_x     (disp_x),
		.disp_y     (disp_y),
		.disp_z     (disp_z),
		.batch_end  (batch_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.wrapped_x  (wrapped_x),
		.wrapped_y  (wrapped_y),
		.wrapped_z  (wrapped_z),
		.batch_last (batch_last)
	);

	always #(CLK_HALF) clk = ~clk;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic longint col_entry(input logic [COL_W-1:0] col, input int row);
		logic signed [ENTRY_W-1:0] e;
		e = col[row*ENTRY_W +: ENTRY_W];
		return longint'(e);
	endfunction

	function automatic wrap_result_t wrap_displacement(input logic signed [DISP_W-1:0] dx,
		input logic signed [DISP_W-1:0] dy, input logic signed [DISP_W-1:0] dz,
		input logic last);
		longint       d[3];
		longint       f[3];
		longint       w[3];
		longint       s, mag, q;
		int           naxes;
		wrap_result_t r;
		d[0] = dx;
		d[1] = dy;
		d[2] = dz;
		w = d;
		f = '{default: 0};
		case (period_sh)
			MODE_X:   naxes = 1;
			MODE_XY:  naxes = 2;
			MODE_XYZ: naxes = 3;
			default:  naxes = 0;
		endcase
		// fractional coordinates in Q.36, nearest whole cell removed
		for (int i = 0; i < naxes; i++) begin
			s = 0;
			for (int j = 0; j < naxes; j++)
				s += col_entry(inv_sh[j], i) * d[j];
			mag = (s < 0) ? -s : s;
			q = (mag + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
			f[i] = (s < 0) ? s + (q <<< FRAC_SHIFT) : s - (q <<< FRAC_SHIFT);
		end
		// back to Cartesian in Q.46, round half away to Q.16 and clamp
		for (int i = 0; i < naxes; i++) begin
			s = 0;
			for (int j = 0; j < naxes; j++)
				s += col_entry(box_sh[j], i) * f[j];
			mag = (s < 0) ? -s : s;
			q = (mag + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
			if (s < 0)
				w[i] = (q > -DISP_MIN) ? DISP_MIN : -q;
			else
				w[i] = (q > DISP_MAX) ? DISP_MAX : q;
		end
		r.x = w[0][DISP_W-1:0];
		r.y = w[1][DISP_W-1:0];
		r.z = w[2][DISP_W-1:0];
		r.last = last;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [DISP_W-1:0] want,
		input logic [DISP_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %08h, actual %08h", name, want, got);
			fail_count++;
		end
	endfunction

	// ------------------------------------------------------------------
	// monitor: register shadow, expectations, result check
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		wrap_result_t want;
		in_taken  = arst_n && in_valid && in_ready;
		cfg_taken = arst_n && cfg_valid && cfg_ready;
		if (cfg_taken) begin
			case (cfg_index)
				REG_PERIOD_MODE: period_sh = mode_e'(cfg_data[1:0]);
				REG_BOX_A:       box_sh[0] = cfg_data;
				REG_BOX_B:       box_sh[1] = cfg_data;
				REG_BOX_C:       box_sh[2] = cfg_data;
				REG_INV_A:       inv_sh[0] = cfg_data;
				REG_INV_B:       inv_sh[1] = cfg_data;
				REG_INV_C:       inv_sh[2] = cfg_data;
				default: ;
			endcase
		end
		if (in_taken)
			wrap_due.push_back(wrap_displacement(disp_x, disp_y, disp_z, batch_end));
		if (arst_n && out_valid && out_ready) begin
			if (wrap_due.size() == 0) begin
				$error("result item with nothing outstanding");
				fail_count++;
			end else begin
				want = wrap_due.pop_front();
				check_field("wrapped_x", want.x, wrapped_x);
				check_field("wrapped_y", want.y, wrapped_y);
				check_field("wrapped_z", want.z, wrapped_z);
				check_field("batch_last", DISP_W'(want.last), DISP_W'(batch_last));
			end
		end
	end

	// ------------------------------------------------------------------
	// driver: bursts of items, register writes only once drained
	// ------------------------------------------------------------------
	always @(negedge clk) begin : driver
		pend_op_t op;
		logic     busy;
		logic     nxt_in;
		logic     nxt_cfg;
		if (arst_n) begin
			busy = (in_valid && !in_taken) || (cfg_valid && !cfg_taken);
			if (!busy) begin
				nxt_in  = 1'b0;
				nxt_cfg = 1'b0;
				if (pending.size() != 0) begin
					op = pending[0];
					case (op.kind)
						OP_DISP: begin
							if (gap_left > 0) begin
								gap_left--;
							end else begin
								void'(pending.pop_front());
								disp_x    <= op.x;
								disp_y    <= op.y;
								disp_z    <= op.z;
								batch_end <= op.last;
								nxt_in = 1'b1;
								burst_left--;
								if (burst_left <= 0) begin
									burst_left = ($urandom_range(0, 7) == 0) ?
										$urandom_range(100, 300) : $urandom_range(1, 24);
									gap_left = ($urandom_range(0, 2) == 0) ?
										0 : $urandom_range(1, 6);
								end
							end
						end
						OP_CFG: begin
							if (wrap_due.size() == 0) begin
								void'(pending.pop_front());
								cfg_index <= op.idx;
								cfg_data  <= op.data;
								nxt_cfg = 1'b1;
							end
						end
						default: begin
							if (wrap_due.size() == 0)
								void'(pending.pop_front());
						end
					endcase
				end
				in_valid  <= nxt_in;
				cfg_valid <= nxt_cfg;
			end
		end
	end

	// output side back-pressure, in one of four styles that is redrawn at random
	always @(negedge clk) begin : receiver
		rx_cycle++;
		if (rx_cycle % 300 == 0)
			rx_style = rx_style_e'($urandom_range(0, 3));
		case (rx_style)
			RX_OPEN:     out_ready <= 1'b1;
			RX_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: out_ready <= ((rx_cycle % 5) >= 2);
			default: begin
				if (rx_hold > 0) begin
					rx_hold--;
					out_ready <= 1'b0;
				end else begin
					if ($urandom_range(0, 11) == 0)
						rx_hold = $urandom_range(4, 20);
					out_ready <= 1'b1;
				end
			end
		endcase
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic real rand_real(input real lo, input real hi);
		return lo + (hi - lo) * (real'($urandom) / 4294967296.0);
	endfunction

	function automatic longint to_fixed(input real v, input real scale);
		return longint'(v * scale);
	endfunction

	function automatic logic [COL_W-1:0] pack_col(input longint e0, input longint e1,
		input longint e2);
		return {e2[ENTRY_W-1:0], e1[ENTRY_W-1:0], e0[ENTRY_W-1:0]};
	endfunction

	function automatic logic [COL_W-1:0] rand_col();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[COL_W-1:0];
	endfunction

	task automatic add_disp(input longint x, input longint y, input longint z,
		input logic last);
		pend_op_t op;
		op.kind = OP_DISP;
		op.x    = x[DISP_W-1:0];
		op.y    = y[DISP_W-1:0];
		op.z    = z[DISP_W-1:0];
		op.last = last;
		op.idx  = '0;
		op.data = '0;
		pending.push_back(op);
	endtask

	task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [COL_W-1:0] data);
		pend_op_t op;
		op.kind = OP_CFG;
		op.x    = '0;
		op.y    = '0;
		op.z    = '0;
		op.last = 1'b0;
		op.idx  = idx;
		op.data = data;
		pending.push_back(op);
	endtask

	task automatic set_mode(input mode_e m);
		logic [COL_W-1:0] v;
		v = rand_col();   // bits above the mode are don't-care
		v[1:0] = m;
		add_cfg(REG_PERIOD_MODE, v);
	endtask

	// random skewed cell: a along x, b in the xy plane, c anywhere
	task automatic add_triclinic(input mode_e m);
		real ax, bx, by, cx, cy, cz;
		ax = rand_real(2.0, 90.0);
		by = rand_real(2.0, 90.0);
		cz = rand_real(2.0, 90.0);
		bx = rand_real(-0.5, 0.5) * ax;
		cx = rand_real(-0.5, 0.5) * ax;
		cy = rand_real(-0.5, 0.5) * by;
		set_mode(m);
		add_cfg(REG_BOX_A, pack_col(to_fixed(ax, BOX_ONE), 0, 0));
		add_cfg(REG_BOX_B, pack_col(to_fixed(bx, BOX_ONE), to_fixed(by, BOX_ONE), 0));
		add_cfg(REG_BOX_C, pack_col(to_fixed(cx, BOX_ONE), to_fixed(cy, BOX_ONE),
			to_fixed(cz, BOX_ONE)));
		// inverse of an upper-triangular matrix, same column layout
		add_cfg(REG_INV_A, pack_col(to_fixed(1.0 / ax, INV_ONE), 0, 0));
		add_cfg(REG_INV_B, pack_col(to_fixed(-bx / (ax * by), INV_ONE),
			to_fixed(1.0 / by, INV_ONE), 0));
		add_cfg(REG_INV_C, pack_col(to_fixed((bx * cy - cx * by) / (ax * by * cz), INV_ONE),
			to_fixed(-cy / (by * cz), INV_ONE), to_fixed(1.0 / cz, INV_ONE)));
		box_span = (ax > by) ? ((ax > cz) ? ax : cz) : ((by > cz) ? by : cz);
	endtask

	task automatic add_random_disps(input int count, input real reach, input bit with_sync);
		pend_op_t sync_op;
		logic     last;
		sync_op = '{kind: OP_SYNC, default: '0};
		for (int k = 0; k < count; k++) begin
			if (with_sync && k == count / 2)
				pending.push_back(sync_op);
			last = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) < 7)
				add_disp(to_fixed(rand_real(-reach, reach), ONE_Q16),
					to_fixed(rand_real(-reach, reach), ONE_Q16),
					to_fixed(rand_real(-reach, reach), ONE_Q16), last);
			else
				add_disp(longint'($urandom), longint'($urandom), longint'($urandom), last);
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin : stimulus
		mode_e m;

		// reset values: everything passes through
		add_disp(DISP_MAX, DISP_MIN, 0, 1'b1);
		add_disp(DISP_MIN, DISP_MAX, -1, 1'b0);
		add_disp(0, 1, -1, 1'b1);

		// cubic 4.0 cell, exact inverse: half-cell points are exact ties
		set_mode(MODE_XYZ);
		add_cfg(REG_BOX_A, pack_col(4096, 0, 0));
		add_cfg(REG_BOX_B, pack_col(0, 4096, 0));
		add_cfg(REG_BOX_C, pack_col(0, 0, 4096));
		add_cfg(REG_INV_A, pack_col(262144, 0, 0));
		add_cfg(REG_INV_B, pack_col(0, 262144, 0));
		add_cfg(REG_INV_C, pack_col(0, 0, 262144));
		add_disp(2 * ONE_Q16, -2 * ONE_Q16, 6 * ONE_Q16, 1'b0);
		add_disp(ONE_Q16, -ONE_Q16, 0, 1'b1);
		add_disp(DISP_MAX, DISP_MIN, DISP_MAX, 1'b0);
		add_disp(DISP_MIN, 0, DISP_MIN, 1'b1);
		add_disp(2 * ONE_Q16 + 1, 2 * ONE_Q16 - 1, -2 * ONE_Q16 - 1, 1'b0);

		set_mode(MODE_X);
		add_cfg(REG_SPARE, rand_col());
		add_disp(2 * ONE_Q16, DISP_MAX, DISP_MIN, 1'b1);
		add_disp(-6 * ONE_Q16, 5 * ONE_Q16, -7 * ONE_Q16, 1'b0);

		set_mode(MODE_XY);
		add_disp(2 * ONE_Q16, 2 * ONE_Q16, 2 * ONE_Q16, 1'b0);
		add_disp(-10 * ONE_Q16, 6 * ONE_Q16, 9 * ONE_Q16, 1'b1);

		// entry extremes
		set_mode(MODE_XYZ);
		add_cfg(REG_BOX_A, pack_col(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN));
		add_cfg(REG_BOX_B, pack_col(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN));
		add_cfg(REG_BOX_C, pack_col(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN));
		add_cfg(REG_INV_A, pack_col(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX));
		add_cfg(REG_INV_B, pack_col(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX));
		add_cfg(REG_INV_C, pack_col(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX));
		add_disp(DISP_MAX, DISP_MAX, DISP_MAX, 1'b0);
		add_disp(DISP_MIN, DISP_MIN, DISP_MIN, 1'b1);
		add_disp(ONE_Q16, -ONE_Q16, ONE_Q16 / 2, 1'b0);
		add_cfg(REG_BOX_A, pack_col(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX));
		add_cfg(REG_BOX_B, pack_col(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX));
		add_cfg(REG_BOX_C, pack_col(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX));
		add_cfg(REG_INV_A, pack_col(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN));
		add_cfg(REG_INV_B, pack_col(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN));
		add_cfg(REG_INV_C, pack_col(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN));
		add_disp(DISP_MAX, DISP_MIN, 0, 1'b1);
		add_disp(-1, 1, DISP_MAX, 1'b0);
		set_mode(MODE_NONE);
		add_disp(DISP_MIN, -1, DISP_MAX, 1'b1);

		// random cells; every fourth set of columns is raw random bits
		for (int p = 0; p < 12; p++) begin
			m = (p < 4) ? mode_e'(3 - p) : mode_e'($urandom_range(0, 3));
			if (p % 4 == 3) begin
				set_mode(m);
				add_cfg(REG_BOX_A, rand_col());
				add_cfg(REG_BOX_B, rand_col());
				add_cfg(REG_BOX_C, rand_col());
				add_cfg(REG_INV_A, rand_col());
				add_cfg(REG_INV_B, rand_col());
				add_cfg(REG_INV_C, rand_col());
				box_span = rand_real(1.0, 100.0);
			end else begin
				add_triclinic(m);
			end
			add_random_disps(150, 2.5 * box_span, p % 2 == 1);
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (pending.size() != 0 || in_valid || cfg_valid)
			@(posedge clk);
		while (wrap_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Regression FAIL");
		$finish;
	end

endmodule
